// ===== src/ffea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffea_pkg: shared types and codes for the first-fit extent allocator
// Request and status codes, table entry layout, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffea_pkg;

	localparam logic [1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [1:0] FUNC_FREE   = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_ENTRY  = 3'd1;
	localparam logic [2:0] ST_TAG_TAKEN = 3'd2;
	localparam logic [2:0] ST_NO_SPACE  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic CFG_DISK_SIZE  = 1'b0;
	localparam logic CFG_DATA_START = 1'b1;

	localparam logic [15:0] DISK_SIZE_RST  = 16'hFFFF;
	localparam logic [15:0] DATA_START_RST = 16'h0000;

	typedef struct packed {
		logic [31:0] tag;
		logic [15:0] start;
		logic [15:0] length;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOVE,
		S_DRAIN,
		S_INS,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic mv_read;
		logic ins;
		logic emit;
	} ffea_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic scan_last;
		logic go_move;
		logic go_ins;
		logic move_last;
		logic ins_pend;
	} ffea_stat_t;

endpackage

// ===== src/ffea_if.sv =====
// ----------------------------------------------------------------------------
// ffea_if: request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface ffea_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] file_tag;
	logic [15:0] req_size;

	modport source(output valid, func, file_tag, req_size, input ready);
	modport sink(input valid, func, file_tag, req_size, output ready);
endinterface

interface ffea_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] extent_start;
	logic [15:0] extent_size;
	logic [15:0] free_bytes;
	logic [4:0]  free_entries;

	modport source(output valid, status, extent_start, extent_size, free_bytes,
		free_entries, input ready);
	modport sink(input valid, status, extent_start, extent_size, free_bytes,
		free_entries, output ready);
endinterface

// ===== src/first_fit_extent_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Sequence: an item is accepted, then the table is scanned one entry at a time
// (no scan when the table is empty), a decide step follows, then any entry
// shifts plus one drain, an insert for an allocation and the result output;
// the scan and shift steps each read one table entry per cycle.
// The output cycle waits while the previous result is still held. One item is
// in flight at a time. Reset: table empty, free bytes = disk size - data start.
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core: first-fit extent allocator top level
// Controller plus datapath over a sorted extent table.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_core import ffea_pkg::*; #(
	parameter int MAX_FILES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ffea_req_if.sink    req,
	ffea_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	ffea_cmd_t  cmd;
	ffea_stat_t stat;

	ffea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffea_datapath #(
		.MAX_FILES(MAX_FILES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_func         (req.func),
		.in_tag          (req.file_tag),
		.in_size         (req.req_size),
		.out_status      (rsp.status),
		.out_start       (rsp.extent_start),
		.out_size        (rsp.extent_size),
		.out_free_bytes  (rsp.free_bytes),
		.out_free_entries(rsp.free_entries)
	);

endmodule

// ===== src/ffea_ram.sv =====
// ----------------------------------------------------------------------------
// ffea_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module ffea_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ffea_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffea_ctrl: allocator sequencer
// Steps each item through scan, decide, shift, insert and result output.
// ----------------------------------------------------------------------------
module ffea_ctrl import ffea_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ffea_stat_t stat,
	output ffea_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = stat.cnt_zero ? S_DECIDE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.go_move) begin
					state_d = S_MOVE;
				end else if (stat.go_ins) begin
					state_d = S_INS;
				end else begin
					state_d = S_OUT;
				end
			end
			S_MOVE: begin
				if (stat.move_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = stat.ins_pend ? S_INS : S_OUT;
			end
			S_INS: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.scan    = (state_q == S_SCAN);
		cmd.decide  = (state_q == S_DECIDE);
		cmd.mv_read = (state_q == S_MOVE);
		cmd.ins     = (state_q == S_INS);
		cmd.emit    = (state_q == S_OUT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/ffea_datapath.sv =====
// ----------------------------------------------------------------------------
// ffea_datapath: extent table, gap search and free-space accounting
// Sorted entry table in RAM, one entry examined per scan cycle, pipelined
// one-entry-per-cycle shifting for insert and remove.
// ----------------------------------------------------------------------------
module ffea_datapath import ffea_pkg::*; #(
	parameter int MAX_FILES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffea_cmd_t   cmd,
	output ffea_stat_t  stat,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  in_func,
	input  logic [31:0] in_tag,
	input  logic [15:0] in_size,
	output logic [2:0]  out_status,
	output logic [15:0] out_start,
	output logic [15:0] out_size,
	output logic [15:0] out_free_bytes,
	output logic [4:0]  out_free_entries
);

	localparam int AW = $clog2(MAX_FILES);
	localparam int CW = $clog2(MAX_FILES + 1);
	localparam int UW = 16 + CW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FILES);

	// configuration and accounting
	logic [15:0]   disk_size_q, data_start_q, bytes_free_q;
	logic [UW-1:0] used_q;
	logic [CW-1:0] cnt_q, cnt_m1, ent_free;

	// request and search state
	logic [1:0]    func_q;
	logic [31:0]   tag_q;
	logic [15:0]   size_q;
	logic [AW-1:0] idx_q, end_q, pos_q, ins_pos_q, found_idx_q, rd_addr_q;
	logic [16:0]   cursor_q;
	logic          gap_q, match_q, mv_q, ins_q, dir_up_q;
	logic [15:0]   found_start_q, found_len_q;
	logic [2:0]    res_status_q;
	logic [15:0]   res_start_q, res_size_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	ffea_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_FILES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// scan step
	logic [16:0] s17, e17;
	logic        fits_before, tag_hit;

	assign s17         = {1'b0, ram_rdata.start};
	assign e17         = s17 + {1'b0, ram_rdata.length};
	assign fits_before = (s17 >= cursor_q) && ((s17 - cursor_q) >= {1'b0, size_q});
	assign tag_hit     = (ram_rdata.tag == tag_q);

	// decision
	logic [16:0]   disk17;
	logic          tail_fits, is_alloc, dec_ok, alloc_ok, free_ok, up_need, dn_need;
	logic [2:0]    dec_status;
	logic [AW-1:0] dec_pos;

	assign cnt_m1    = cnt_q - 1'b1;
	assign ent_free  = MAX_CNT - cnt_q;
	assign disk17    = {1'b0, disk_size_q};
	assign tail_fits = (disk17 >= cursor_q) && ((disk17 - cursor_q) >= {1'b0, size_q});
	assign is_alloc  = (func_q == FUNC_ALLOC);

	always_comb begin
		dec_status = ST_OK;
		dec_pos    = pos_q;
		if (is_alloc) begin
			if (cnt_q == MAX_CNT) begin
				dec_status = ST_NO_ENTRY;
			end else if (match_q) begin
				dec_status = ST_TAG_TAKEN;
			end else if (bytes_free_q < size_q) begin
				dec_status = ST_NO_SPACE;
			end else if (!gap_q) begin
				if (tail_fits) begin
					dec_pos = cnt_q[AW-1:0];
				end else begin
					dec_status = ST_NO_SPACE;
				end
			end
		end else if (!match_q) begin
			dec_status = ST_NOT_FOUND;
		end
	end

	assign dec_ok   = (dec_status == ST_OK);
	assign alloc_ok = is_alloc && dec_ok;
	assign free_ok  = (func_q == FUNC_FREE) && dec_ok;
	assign up_need  = alloc_ok && (CW'(dec_pos) != cnt_q);
	assign dn_need  = free_ok && (CW'(found_idx_q) != cnt_m1);

	always_comb begin
		stat           = '0;
		stat.cnt_zero  = (cnt_q == '0);
		stat.scan_last = (CW'(idx_q) == cnt_m1);
		stat.go_move   = up_need || dn_need;
		stat.go_ins    = alloc_ok && !up_need;
		stat.move_last = (idx_q == end_q);
		stat.ins_pend  = ins_q;
	end

	// RAM ports
	always_comb begin
		if (cmd.scan) begin
			ram_raddr = idx_q + 1'b1;
		end else if (cmd.mv_read) begin
			ram_raddr = idx_q;
		end else begin
			ram_raddr = '0;
		end
	end

	assign ram_we    = mv_q || cmd.ins;
	assign ram_waddr = cmd.ins ? ins_pos_q :
		(dir_up_q ? rd_addr_q + 1'b1 : rd_addr_q - 1'b1);
	assign ram_wdata = cmd.ins ? entry_t'{tag: tag_q, start: res_start_q, length: size_q}
		: ram_rdata;

	// configuration recompute
	logic [15:0]   new_disk, new_ds, span;
	logic [UW-1:0] span_w, span_left;

	assign new_disk  = (cfg_index == CFG_DISK_SIZE) ? cfg_data : disk_size_q;
	assign new_ds    = (cfg_index == CFG_DATA_START) ? cfg_data : data_start_q;
	assign span      = (new_disk >= new_ds) ? new_disk - new_ds : 16'd0;
	assign span_w    = UW'(span);
	assign span_left = span_w - used_q;

	logic [16:0] free_sum;
	assign free_sum = {1'b0, bytes_free_q} + {1'b0, found_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q  <= DISK_SIZE_RST;
			data_start_q <= DATA_START_RST;
			bytes_free_q <= DISK_SIZE_RST - DATA_START_RST;
			used_q       <= '0;
			cnt_q        <= '0;
			gap_q        <= 1'b0;
			match_q      <= 1'b0;
			mv_q         <= 1'b0;
			ins_q        <= 1'b0;
		end else begin
			mv_q <= cmd.mv_read;
			if (cfg_we) begin
				if (cfg_index == CFG_DISK_SIZE) begin
					disk_size_q <= cfg_data;
				end else begin
					data_start_q <= cfg_data;
				end
				bytes_free_q <= (span_w >= used_q) ? span_left[15:0] : 16'd0;
			end else if (cmd.decide) begin
				if (alloc_ok) begin
					bytes_free_q <= bytes_free_q - size_q;
					used_q       <= used_q + UW'(size_q);
					cnt_q        <= cnt_q + 1'b1;
				end else if (free_ok) begin
					bytes_free_q <= free_sum[16] ? 16'hFFFF : free_sum[15:0];
					used_q       <= used_q - UW'(found_len_q);
					cnt_q        <= cnt_m1;
				end
			end
			if (cmd.load) begin
				gap_q   <= 1'b0;
				match_q <= 1'b0;
			end else if (cmd.scan) begin
				if (tag_hit) begin
					match_q <= 1'b1;
				end
				if (!gap_q && fits_before) begin
					gap_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				ins_q <= alloc_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_func;
			tag_q    <= in_tag;
			size_q   <= in_size;
			cursor_q <= {1'b0, data_start_q};
			idx_q    <= '0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (tag_hit && !match_q) begin
				found_idx_q   <= idx_q;
				found_start_q <= ram_rdata.start;
				found_len_q   <= ram_rdata.length;
			end
			if (!gap_q) begin
				if (fits_before) begin
					pos_q <= idx_q;
				end else if (e17 > cursor_q) begin
					cursor_q <= e17;
				end
			end
		end else if (cmd.decide) begin
			res_status_q <= dec_status;
			res_start_q  <= alloc_ok ? cursor_q[15:0] : (dec_ok ? found_start_q : 16'd0);
			res_size_q   <= alloc_ok ? size_q : (dec_ok ? found_len_q : 16'd0);
			ins_pos_q    <= dec_pos;
			dir_up_q     <= is_alloc;
			idx_q        <= is_alloc ? cnt_m1[AW-1:0] : found_idx_q + 1'b1;
			end_q        <= is_alloc ? dec_pos : cnt_m1[AW-1:0];
		end else if (cmd.mv_read) begin
			rd_addr_q <= idx_q;
			idx_q     <= dir_up_q ? idx_q - 1'b1 : idx_q + 1'b1;
		end
		if (cmd.emit) begin
			out_status       <= res_status_q;
			out_start        <= res_start_q;
			out_size         <= res_size_q;
			out_free_bytes   <= bytes_free_q;
			out_free_entries <= 5'(ent_free);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("entry count beyond table depth");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && mv_q))
		else $error("insert collides with shift write");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !ram_we)
		else $error("table written during scan");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide && alloc_ok && !cfg_we |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("allocate did not take an entry");

endmodule
